@@ hw/rtl/obp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package obp_pkg;

  // fixed field widths
  localparam int ITEM_W     = 16;
  localparam int CAP_W      = 16;
  localparam int POL_W      = 2;
  localparam int IDX_OUT_W  = 8;
  localparam int CNT_OUT_W  = 9;
  localparam int APB_DW     = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_SEL_B  = 2;

  // default sizing
  localparam int DEF_MAX_BINS    = 256;
  localparam int DEF_WEIGHT_BITS = 16;

  // register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;
  localparam logic [POL_W-1:0] POL_RESET = 2'd1;

  // register select (address bit 2)
  localparam logic REG_CAP = 1'b0;
  localparam logic REG_POL = 1'b1;

  // placement policy codes, any other code is best fit
  localparam logic [POL_W-1:0] POL_NEXT  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0] bin_capacity;
    logic [POL_W-1:0] placement_policy;
  } obp_cfg_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] bin_index;
    logic [CNT_OUT_W-1:0] bin_count;
    logic                 opened_new_bin;
    logic                 oversize_item;
    logic                 table_full_reject;
    logic                 set_done;
  } obp_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NF,
    ST_SCAN,
    ST_UPD,
    ST_OPEN,
    ST_FIN
  } obp_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/online_bin_packer.sv @@
// next fit runs ST_NF, then ST_OPEN when the item does not fit, then ST_FIN; first and
//   best fit run ST_SCAN (the memory read port scanning one bin per cycle), ST_UPD,
//   ST_OPEN when no bin fits, then ST_FIN; in_ready is high only between words,
//   and the last step waits while the previous result word is not yet taken
// reset (rst_n, synchronous, active low): empty bin set, capacity 65535, first fit;
//   bin space memory needs no clearing, entries are written before they are read
`timescale 1ns / 1ps
`default_nettype none

module online_bin_packer #(
  parameter int MAX_BINS    = obp_pkg::DEF_MAX_BINS,
  parameter int WEIGHT_BITS = obp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [obp_pkg::ITEM_W-1:0]    in_item_weight,
  input  wire logic                          in_last_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [obp_pkg::IDX_OUT_W-1:0]      out_bin_index,
  output logic [obp_pkg::CNT_OUT_W-1:0]      out_bin_count,
  output logic                               out_opened_new_bin,
  output logic                               out_oversize_item,
  output logic                               out_table_full_reject,
  output logic                               out_set_done,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [obp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [obp_pkg::APB_DW-1:0]    pwdata,
  output logic [obp_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  import obp_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [POL_W-1:0] pol_r;
  logic             reg_wr;
  obp_cfg_t         cfg;
  obp_result_t      res;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      pol_r <= POL_RESET;
    end else if (reg_wr) begin
      unique case (paddr[REG_SEL_B])
        REG_CAP: cap_r <= pwdata[CAP_W-1:0];
        REG_POL: pol_r <= pwdata[POL_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[REG_SEL_B])
      REG_POL: prdata = APB_DW'(pol_r);
      default: prdata = APB_DW'(cap_r);
    endcase
  end

  assign cfg.bin_capacity     = cap_r;
  assign cfg.placement_policy = pol_r;

  obp_engine #(
    .MAX_BINS    (MAX_BINS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item_weight (in_item_weight),
    .in_last_item   (in_last_item),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (res)
  );

  assign out_bin_index         = res.bin_index;
  assign out_bin_count         = res.bin_count;
  assign out_opened_new_bin    = res.opened_new_bin;
  assign out_oversize_item     = res.oversize_item;
  assign out_table_full_reject = res.table_full_reject;
  assign out_set_done          = res.set_done;

endmodule

`default_nettype wire

@@ hw/rtl/obp_space_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module obp_space_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic          re,
  input  wire logic [AW-1:0] ra,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/obp_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module obp_engine #(
  parameter int MAX_BINS    = obp_pkg::DEF_MAX_BINS,
  parameter int WEIGHT_BITS = obp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [obp_pkg::ITEM_W-1:0]  in_item_weight,
  input  wire logic                        in_last_item,
  input  wire obp_pkg::obp_cfg_t           cfg,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output obp_pkg::obp_result_t             out_res
);

  import obp_pkg::*;

  localparam int WB = (WEIGHT_BITS < ITEM_W) ? WEIGHT_BITS : ITEM_W;
  localparam int SW = WB + 1;
  localparam int DW = WB + 2;
  localparam int IW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

  obp_state_t state_r, state_nxt;

  // control state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-word working registers
  logic [WB-1:0] w_r, w_nxt;
  logic          last_r, last_nxt;
  logic          over_r, over_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          cmpv_r, cmpv_nxt;
  logic [IW-1:0] cmpj_r, cmpj_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          rej_r, rej_nxt;
  obp_result_t   res_r, res_nxt;

  // memory port signals
  logic          ram_we;
  logic [IW-1:0] ram_wa;
  logic [SW-1:0] ram_wd;
  logic          ram_re;
  logic [SW-1:0] ram_rd;

  // shared subtract/compare unit
  logic [WB-1:0] cap_w;
  logic [SW-1:0] alu_a;
  logic [DW-1:0] diff;
  logic [SW-1:0] diff_sw;
  logic          alu_ok;
  logic          issue;
  logic [CW-1:0] cnt_m1;

  assign cap_w   = cfg.bin_capacity[WB-1:0];
  assign diff    = {alu_a[SW-1], alu_a} - {2'b00, w_r};
  assign diff_sw = diff[SW-1:0];
  assign alu_ok  = ~diff[DW-1];
  assign cnt_m1  = cnt_r - 1'b1;
  assign issue   = (scan_r < cnt_r);

  // operand select for the shared unit
  always_comb begin
    unique case (state_r)
      ST_NF:   alu_a = cur_r;
      ST_OPEN: alu_a = {1'b0, cap_w};
      default: alu_a = ram_rd;
    endcase
  end

  obp_space_ram #(
    .DEPTH (MAX_BINS),
    .AW    (IW),
    .DW    (SW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wa      (ram_wa),
    .wd      (ram_wd),
    .re      (ram_re),
    .ra      (scan_r[IW-1:0]),
    .rd_data (ram_rd)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // sequencer: next state, datapath updates and memory control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    w_nxt         = w_r;
    last_nxt      = last_r;
    over_nxt      = over_r;
    start_nxt     = start_r;
    scan_nxt      = scan_r;
    cmpv_nxt      = cmpv_r;
    cmpj_nxt      = cmpj_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    rej_nxt       = rej_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_wa        = '0;
    ram_wd        = diff_sw;
    ram_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          w_nxt     = in_item_weight[WB-1:0];
          last_nxt  = in_last_item;
          over_nxt  = (in_item_weight[WB-1:0] > cap_w);
          start_nxt = cnt_r;
          found_nxt = 1'b0;
          rej_nxt   = 1'b0;
          idx_nxt   = '0;
          scan_nxt  = '0;
          cmpv_nxt  = 1'b0;
          if (cfg.placement_policy == POL_NEXT) begin
            state_nxt = ST_NF;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // next fit: open bin 0 at full capacity first, then try the current bin
      ST_NF: begin
        if (cnt_r == '0) begin
          ram_we  = 1'b1;
          ram_wa  = '0;
          ram_wd  = {1'b0, cap_w};
          cur_nxt = {1'b0, cap_w};
          cnt_nxt = CW'(1);
        end else if (alu_ok) begin
          ram_we    = 1'b1;
          ram_wa    = cnt_m1[IW-1:0];
          cur_nxt   = diff_sw;
          idx_nxt   = cnt_m1[IW-1:0];
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_OPEN;
        end
      end

      // first/best fit: one read issued and one compare per cycle
      ST_SCAN: begin
        ram_re   = issue;
        cmpv_nxt = issue;
        cmpj_nxt = scan_r[IW-1:0];
        if (issue) begin
          scan_nxt = scan_r + 1'b1;
        end
        if (cmpv_r && alu_ok) begin
          if (cfg.placement_policy == POL_FIRST) begin
            found_nxt = 1'b1;
            pick_nxt  = cmpj_r;
            best_nxt  = diff_sw;
            state_nxt = ST_UPD;
          end else if (!found_r || (diff_sw < best_r)) begin
            found_nxt = 1'b1;
            pick_nxt  = cmpj_r;
            best_nxt  = diff_sw;
          end
        end
        if (!cmpv_r && !issue) begin
          state_nxt = ST_UPD;
        end
      end

      // write back the chosen bin, or go open a new one
      ST_UPD: begin
        if (found_r) begin
          ram_we  = 1'b1;
          ram_wa  = pick_r;
          ram_wd  = best_r;
          idx_nxt = pick_r;
          if ((CW'(pick_r) + 1'b1) == cnt_r) begin
            cur_nxt = best_r;
          end
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_OPEN;
        end
      end

      // new bin with capacity minus weight, or reject when the table is full
      ST_OPEN: begin
        if (cnt_r >= MAX_CNT) begin
          rej_nxt = 1'b1;
          idx_nxt = '0;
        end else begin
          ram_we  = 1'b1;
          ram_wa  = cnt_r[IW-1:0];
          cur_nxt = diff_sw;
          idx_nxt = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_FIN;
      end

      // hand the word to the output register, clear the set after the last item
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          res_nxt.bin_index         = IDX_OUT_W'(idx_r);
          res_nxt.bin_count         = CNT_OUT_W'(cnt_r);
          res_nxt.opened_new_bin    = ~rej_r & (cnt_r > start_r);
          res_nxt.oversize_item     = over_r;
          res_nxt.table_full_reject = rej_r;
          res_nxt.set_done          = last_r;
          out_valid_nxt             = 1'b1;
          if (last_r) begin
            cnt_nxt = '0;
            cur_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    last_r  <= last_nxt;
    over_r  <= over_nxt;
    start_r <= start_nxt;
    scan_r  <= scan_nxt;
    cmpv_r  <= cmpv_nxt;
    cmpj_r  <= cmpj_nxt;
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
    best_r  <= best_nxt;
    idx_r   <= idx_nxt;
    rej_r   <= rej_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire
